// ===== hdl/grid_dda_ray_caster_core_defines.svh =====
// assertion macros used by the checker file of the ray caster core
// no dependencies; included by bare file name
`ifndef GRID_DDA_RAY_CASTER_CORE_DEFINES_SVH
`define GRID_DDA_RAY_CASTER_CORE_DEFINES_SVH

// same-cycle implication
`define GDRC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdrc check failed");

// next-cycle implication
`define GDRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdrc check failed");

`endif

// ===== hdl/gdrc_pkg.sv =====
// shared constants, command and status types of the ray caster core
// no dependencies
package gdrc_pkg;

   localparam int MAP_WIDTH  = 32;
   localparam int MAP_HEIGHT = 32;
   localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int STEP_LIMIT = MAP_WIDTH + MAP_HEIGHT + 1;
   localparam int STEP_CNT_W = $clog2(STEP_LIMIT + 1);
   localparam int COORD_W    = 8;

   localparam int CELL_W     = 8;
   localparam int IDX_W      = 10;
   localparam int COL_W      = 11;
   localparam int POS_W      = 16;
   localparam int FRAC_W     = 10;
   localparam int VEC_W      = 16;
   localparam int RCNT_W     = 12;
   localparam int RAY_W      = 19;
   localparam int DELTA_W    = 24;
   localparam int SIDE_W     = 32;
   localparam int DIST_W     = 18;

   localparam int DIV_DVD_W  = 32;
   localparam int DIV_DVS_W  = 20;
   localparam int DIV_CNT_W  = $clog2(DIV_DVD_W);

   localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_PLAYER_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLAYER_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RAY_COUNT = 3'd6;

   localparam logic [POS_W-1:0]         RST_PLAYER_X  = 16'd40960;
   localparam logic [POS_W-1:0]         RST_PLAYER_Y  = 16'd40960;
   localparam logic signed [VEC_W-1:0]  RST_DIR_X     = 16'sd0;
   localparam logic signed [VEC_W-1:0]  RST_DIR_Y     = 16'sd16384;
   localparam logic signed [VEC_W-1:0]  RST_PLANE_X   = 16'sd10813;
   localparam logic signed [VEC_W-1:0]  RST_PLANE_Y   = 16'sd0;
   localparam logic [RCNT_W-1:0]        RST_RAY_COUNT = 12'd800;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CAST  = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_DIV_CAM,
      OP_CAM,
      OP_MUL_X,
      OP_MUL_Y,
      OP_RAY_Y,
      OP_DIV_DX,
      OP_DX,
      OP_DIV_DY,
      OP_DY,
      OP_SIDE_X,
      OP_SIDE_Y,
      OP_STEP,
      OP_LOOK,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      accept;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic step_out;
      logic cell_hit;
      logic count_last;
   } dp_status_type;

endpackage

// ===== hdl/grid_dda_ray_caster_core.sv =====
// top level of the grid ray caster: controller plus datapath
// depends on gdrc_pkg, gdrc_ctrl and gdrc_datapath
//
// usage
//   req channel (valid/ready) carries one transaction per item: kind 0 writes
//   req_cell_value into map cell req_cell_index (out of range is dropped),
//   kind 1 casts the ray of screen column req_column
//   rsp channel (valid/ready) returns one transaction per cast, none per write
//   csr port writes the camera registers by index; the user must write them
//   only while the core is idle, as the core itself does not enforce this
//   a cast runs three passes of the shared serial divider (camera x, then
//   1/|ray x|, then 1/|ray y|) and then walks 1 to map width + height + 1
//   cells, each step that stays in the grid checked by a registered map read
//   one cast is in flight at a time; a finished result sits in the rsp
//   register while the next transaction is accepted
//   reset: the map store is zeroed by a sweep of one cell per cycle with
//   req_ready low; csr writes still land
//   receiver stall: a cast that finishes while rsp is still held waits until
//   the held result is taken
module grid_dda_ray_caster_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [gdrc_pkg::IDX_W-1:0]        req_cell_index,
   input  logic [gdrc_pkg::CELL_W-1:0]       req_cell_value,
   input  logic [gdrc_pkg::COL_W-1:0]        req_column,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gdrc_pkg::COL_W-1:0]        rsp_ray_column,
   output logic [gdrc_pkg::DIST_W-1:0]       rsp_wall_distance,
   output logic                              rsp_hit_side,
   output logic [gdrc_pkg::CELL_W-1:0]       rsp_wall_value,
   output logic                              rsp_out_of_bounds,
   input  logic                              csr_wr_en,
   input  logic [gdrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gdrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // command and status between sequencer and datapath
   gdrc_pkg::dp_cmd_type    cmd;
   gdrc_pkg::dp_status_type status;

   gdrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   gdrc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_kind),
      .req_cell_index    (req_cell_index),
      .req_cell_value    (req_cell_value),
      .req_column        (req_column),
      .rsp_ray_column    (rsp_ray_column),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_hit_side      (rsp_hit_side),
      .rsp_wall_value    (rsp_wall_value),
      .rsp_out_of_bounds (rsp_out_of_bounds)
   );

endmodule

// ===== hdl/gdrc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on gdrc_pkg
module gdrc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [gdrc_pkg::DIV_DVD_W-1:0]   dividend,
   input  logic [gdrc_pkg::DIV_DVS_W-1:0]   divisor,
   output logic                             done,
   output logic [gdrc_pkg::DIV_DVD_W-1:0]   quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [gdrc_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [gdrc_pkg::DIV_DVS_W-1:0]   rem_ff, rem_in;
   logic [gdrc_pkg::DIV_DVS_W-1:0]   dvs_ff, dvs_in;
   logic [gdrc_pkg::DIV_DVD_W-1:0]   quo_ff, quo_in;
   logic [gdrc_pkg::DIV_DVS_W:0]     rem_sh;
   logic [gdrc_pkg::DIV_DVS_W:0]     rem_sub;
   logic                             fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[gdrc_pkg::DIV_DVD_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[gdrc_pkg::DIV_DVS_W-1:0] : rem_sh[gdrc_pkg::DIV_DVS_W-1:0];
         quo_in = {quo_ff[gdrc_pkg::DIV_DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gdrc_pkg::DIV_CNT_W'(gdrc_pkg::DIV_DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/gdrc_datapath.sv =====
// datapath: config registers, map store, ray setup arithmetic and grid walk
// depends on gdrc_pkg and gdrc_div
module gdrc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gdrc_pkg::dp_cmd_type              cmd,
   output gdrc_pkg::dp_status_type           status,
   input  logic                              csr_wr_en,
   input  logic [gdrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gdrc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_kind,
   input  logic [gdrc_pkg::IDX_W-1:0]        req_cell_index,
   input  logic [gdrc_pkg::CELL_W-1:0]       req_cell_value,
   input  logic [gdrc_pkg::COL_W-1:0]        req_column,
   output logic [gdrc_pkg::COL_W-1:0]        rsp_ray_column,
   output logic [gdrc_pkg::DIST_W-1:0]       rsp_wall_distance,
   output logic                              rsp_hit_side,
   output logic [gdrc_pkg::CELL_W-1:0]       rsp_wall_value,
   output logic                              rsp_out_of_bounds
);

   // configuration
   logic [gdrc_pkg::POS_W-1:0]          player_x_ff, player_y_ff;
   logic signed [gdrc_pkg::VEC_W-1:0]   dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [gdrc_pkg::RCNT_W-1:0]         ray_count_ff;

   // map store
   logic [gdrc_pkg::CELL_W-1:0]  mem [gdrc_pkg::CELL_COUNT];
   logic [gdrc_pkg::CELL_W-1:0]  rd_data_ff;
   logic [gdrc_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
   logic [gdrc_pkg::CELL_W-1:0]  wr_data;
   logic                         wr_en;
   logic [gdrc_pkg::ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // ray state
   logic [gdrc_pkg::COL_W-1:0]          col_ff, col_in;
   logic signed [gdrc_pkg::VEC_W-1:0]   cam_ff, cam_in;
   logic signed [31:0]                  prod_ff, prod_in;
   logic signed [gdrc_pkg::RAY_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [gdrc_pkg::DELTA_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [gdrc_pkg::SIDE_W-1:0]         sx_ff, sx_in, sy_ff, sy_in;
   logic signed [gdrc_pkg::COORD_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [gdrc_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                                side_ff, side_in;
   logic                                oob_ff, oob_in;
   logic [gdrc_pkg::CELL_W-1:0]         value_ff, value_in;

   // result register
   logic [gdrc_pkg::COL_W-1:0]   out_col_ff, out_col_in;
   logic [gdrc_pkg::DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic                         out_side_ff, out_side_in;
   logic [gdrc_pkg::CELL_W-1:0]  out_value_ff, out_value_in;
   logic                         out_oob_ff, out_oob_in;

   // divider hookup
   logic                               div_start, div_done;
   logic [gdrc_pkg::DIV_DVD_W-1:0]     div_dividend, div_quotient;
   logic [gdrc_pkg::DIV_DVS_W-1:0]     div_divisor;
   logic [gdrc_pkg::RCNT_W-1:0]        rc_eff;
   logic [gdrc_pkg::RAY_W-1:0]         rx_abs, ry_abs;
   logic [gdrc_pkg::DELTA_W-1:0]       delta_q;

   // walk helpers
   logic                                take_x, step_neg_x, step_neg_y, step_out;
   logic signed [gdrc_pkg::COORD_W-1:0] mx_nx, my_nx;
   logic [gdrc_pkg::FRAC_W:0]           f_x, f_y;
   logic [gdrc_pkg::DELTA_W+gdrc_pkg::FRAC_W:0] start_x, start_y;
   logic [gdrc_pkg::SIDE_W-1:0]         dist_diff;
   logic [gdrc_pkg::SIDE_W-7:0]         dist_sh;

   gdrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      rc_eff = (ray_count_ff == '0) ? gdrc_pkg::RCNT_W'(1) : ray_count_ff;
      rx_abs = rx_ff[gdrc_pkg::RAY_W-1] ? gdrc_pkg::RAY_W'(-rx_ff) : gdrc_pkg::RAY_W'(rx_ff);
      ry_abs = ry_ff[gdrc_pkg::RAY_W-1] ? gdrc_pkg::RAY_W'(-ry_ff) : gdrc_pkg::RAY_W'(ry_ff);
      div_start = (cmd.op == gdrc_pkg::OP_DIV_CAM) || (cmd.op == gdrc_pkg::OP_DIV_DX) ||
                  (cmd.op == gdrc_pkg::OP_DIV_DY);
      case (cmd.op)
         gdrc_pkg::OP_DIV_CAM: begin
            div_dividend = gdrc_pkg::DIV_DVD_W'({col_ff, 15'd0});
            div_divisor  = gdrc_pkg::DIV_DVS_W'(rc_eff);
         end
         gdrc_pkg::OP_DIV_DX: begin
            div_dividend = gdrc_pkg::DIV_DVD_W'(32'h4000_0000);
            div_divisor  = gdrc_pkg::DIV_DVS_W'(rx_abs);
         end
         default: begin
            div_dividend = gdrc_pkg::DIV_DVD_W'(32'h4000_0000);
            div_divisor  = gdrc_pkg::DIV_DVS_W'(ry_abs);
         end
      endcase
      // divide by zero gives all ones, which saturates too
      delta_q = (|div_quotient[gdrc_pkg::DIV_DVD_W-1:gdrc_pkg::DELTA_W]) ?
                gdrc_pkg::DELTA_MAX : div_quotient[gdrc_pkg::DELTA_W-1:0];
   end

   // walk step: ties go to y, rows grow downward
   always_comb begin
      take_x     = sx_ff < sy_ff;
      step_neg_x = rx_ff < 0;
      step_neg_y = ry_ff > 0;
      mx_nx = mx_ff;
      my_nx = my_ff;
      if (take_x) begin
         mx_nx = step_neg_x ? mx_ff - gdrc_pkg::COORD_W'(1) : mx_ff + gdrc_pkg::COORD_W'(1);
      end else begin
         my_nx = step_neg_y ? my_ff - gdrc_pkg::COORD_W'(1) : my_ff + gdrc_pkg::COORD_W'(1);
      end
      step_out = mx_nx[gdrc_pkg::COORD_W-1] || my_nx[gdrc_pkg::COORD_W-1] ||
                 (mx_nx >= gdrc_pkg::COORD_W'(gdrc_pkg::MAP_WIDTH)) ||
                 (my_nx >= gdrc_pkg::COORD_W'(gdrc_pkg::MAP_HEIGHT));
      rd_addr = gdrc_pkg::ADDR_W'(my_nx) * gdrc_pkg::ADDR_W'(gdrc_pkg::MAP_WIDTH) +
                gdrc_pkg::ADDR_W'(mx_nx);
      f_x = step_neg_x ? {1'b0, player_x_ff[gdrc_pkg::FRAC_W-1:0]} :
            (gdrc_pkg::FRAC_W+1)'(1024) - {1'b0, player_x_ff[gdrc_pkg::FRAC_W-1:0]};
      f_y = step_neg_y ? {1'b0, player_y_ff[gdrc_pkg::FRAC_W-1:0]} :
            (gdrc_pkg::FRAC_W+1)'(1024) - {1'b0, player_y_ff[gdrc_pkg::FRAC_W-1:0]};
      start_x = (gdrc_pkg::DELTA_W+gdrc_pkg::FRAC_W+1)'(dx_ff) *
                (gdrc_pkg::DELTA_W+gdrc_pkg::FRAC_W+1)'(f_x);
      start_y = (gdrc_pkg::DELTA_W+gdrc_pkg::FRAC_W+1)'(dy_ff) *
                (gdrc_pkg::DELTA_W+gdrc_pkg::FRAC_W+1)'(f_y);
      dist_diff = side_ff ? sy_ff - gdrc_pkg::SIDE_W'(dy_ff) : sx_ff - gdrc_pkg::SIDE_W'(dx_ff);
      dist_sh   = dist_diff[gdrc_pkg::SIDE_W-1:6];
   end

   // map store write mux
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      if (cmd.op == gdrc_pkg::OP_CLEAR) begin
         wr_en = 1'b1;
      end else if (cmd.accept && (req_kind == gdrc_pkg::KIND_WRITE) &&
                   (32'(req_cell_index) < gdrc_pkg::CELL_COUNT)) begin
         wr_en   = 1'b1;
         wr_addr = gdrc_pkg::ADDR_W'(req_cell_index);
         wr_data = req_cell_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.op == gdrc_pkg::OP_STEP) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      clr_addr_in  = clr_addr_ff;
      col_in       = col_ff;
      cam_in       = cam_ff;
      prod_in      = prod_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      cnt_in       = cnt_ff;
      side_in      = side_ff;
      oob_in       = oob_ff;
      value_in     = value_ff;
      out_col_in   = out_col_ff;
      out_dist_in  = out_dist_ff;
      out_side_in  = out_side_ff;
      out_value_in = out_value_ff;
      out_oob_in   = out_oob_ff;
      if (cmd.accept && (req_kind == gdrc_pkg::KIND_CAST)) begin
         col_in = req_column;
      end
      case (cmd.op)
         gdrc_pkg::OP_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         gdrc_pkg::OP_CAM: begin
            // camera x, clamped just under 2.0
            cam_in = (div_quotient > 32'd49151) ? 16'sd32767 :
                     gdrc_pkg::VEC_W'(div_quotient - 32'd16384);
         end
         gdrc_pkg::OP_MUL_X: begin
            prod_in = 32'(plane_x_ff) * 32'(cam_ff);
         end
         gdrc_pkg::OP_MUL_Y: begin
            rx_in   = gdrc_pkg::RAY_W'(dir_x_ff) + gdrc_pkg::RAY_W'(prod_ff >>> 14);
            prod_in = 32'(plane_y_ff) * 32'(cam_ff);
         end
         gdrc_pkg::OP_RAY_Y: begin
            ry_in = gdrc_pkg::RAY_W'(dir_y_ff) + gdrc_pkg::RAY_W'(prod_ff >>> 14);
         end
         gdrc_pkg::OP_DX: begin
            dx_in = delta_q;
         end
         gdrc_pkg::OP_DY: begin
            dy_in = delta_q;
         end
         gdrc_pkg::OP_SIDE_X: begin
            sx_in = gdrc_pkg::SIDE_W'(start_x >> gdrc_pkg::FRAC_W);
            mx_in = gdrc_pkg::COORD_W'(player_x_ff[gdrc_pkg::POS_W-1:gdrc_pkg::FRAC_W]);
            cnt_in = '0;
         end
         gdrc_pkg::OP_SIDE_Y: begin
            sy_in = gdrc_pkg::SIDE_W'(start_y >> gdrc_pkg::FRAC_W);
            my_in = gdrc_pkg::COORD_W'(player_y_ff[gdrc_pkg::POS_W-1:gdrc_pkg::FRAC_W]);
         end
         gdrc_pkg::OP_STEP: begin
            if (take_x) begin
               sx_in   = sx_ff + gdrc_pkg::SIDE_W'(dx_ff);
               side_in = 1'b0;
            end else begin
               sy_in   = sy_ff + gdrc_pkg::SIDE_W'(dy_ff);
               side_in = 1'b1;
            end
            mx_in    = mx_nx;
            my_in    = my_nx;
            cnt_in   = cnt_ff + 1'b1;
            oob_in   = 1'b1;
            value_in = '0;
         end
         gdrc_pkg::OP_LOOK: begin
            value_in = rd_data_ff;
            oob_in   = (rd_data_ff == '0);
         end
         gdrc_pkg::OP_RESULT: begin
            out_col_in   = col_ff;
            out_dist_in  = (|dist_sh[gdrc_pkg::SIDE_W-7:gdrc_pkg::DIST_W]) ?
                           gdrc_pkg::DIST_MAX : dist_sh[gdrc_pkg::DIST_W-1:0];
            out_side_in  = side_ff;
            out_value_in = value_ff;
            out_oob_in   = oob_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff  <= gdrc_pkg::RST_PLAYER_X;
         player_y_ff  <= gdrc_pkg::RST_PLAYER_Y;
         dir_x_ff     <= gdrc_pkg::RST_DIR_X;
         dir_y_ff     <= gdrc_pkg::RST_DIR_Y;
         plane_x_ff   <= gdrc_pkg::RST_PLANE_X;
         plane_y_ff   <= gdrc_pkg::RST_PLANE_Y;
         ray_count_ff <= gdrc_pkg::RST_RAY_COUNT;
         clr_addr_ff  <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         if (csr_wr_en) begin
            case (csr_index)
               gdrc_pkg::REG_PLAYER_X:  player_x_ff  <= csr_wdata;
               gdrc_pkg::REG_PLAYER_Y:  player_y_ff  <= csr_wdata;
               gdrc_pkg::REG_DIR_X:     dir_x_ff     <= csr_wdata;
               gdrc_pkg::REG_DIR_Y:     dir_y_ff     <= csr_wdata;
               gdrc_pkg::REG_PLANE_X:   plane_x_ff   <= csr_wdata;
               gdrc_pkg::REG_PLANE_Y:   plane_y_ff   <= csr_wdata;
               gdrc_pkg::REG_RAY_COUNT: ray_count_ff <= csr_wdata[gdrc_pkg::RCNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      col_ff       <= col_in;
      cam_ff       <= cam_in;
      prod_ff      <= prod_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      cnt_ff       <= cnt_in;
      side_ff      <= side_in;
      oob_ff       <= oob_in;
      value_ff     <= value_in;
      out_col_ff   <= out_col_in;
      out_dist_ff  <= out_dist_in;
      out_side_ff  <= out_side_in;
      out_value_ff <= out_value_in;
      out_oob_ff   <= out_oob_in;
   end

   assign status.clear_last = (clr_addr_ff == gdrc_pkg::ADDR_W'(gdrc_pkg::CELL_COUNT - 1));
   assign status.div_done   = div_done;
   assign status.step_out   = step_out;
   assign status.cell_hit   = (rd_data_ff != '0);
   assign status.count_last = (cnt_ff == gdrc_pkg::STEP_CNT_W'(gdrc_pkg::STEP_LIMIT));

   assign rsp_ray_column    = out_col_ff;
   assign rsp_wall_distance = out_dist_ff;
   assign rsp_hit_side      = out_side_ff;
   assign rsp_wall_value    = out_value_ff;
   assign rsp_out_of_bounds = out_oob_ff;

endmodule

// ===== hdl/gdrc_ctrl.sv =====
// controller state machine: clearing sweep, cast sequencing, handshakes
// depends on gdrc_pkg
module gdrc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_kind,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gdrc_pkg::dp_cmd_type      cmd,
   input  gdrc_pkg::dp_status_type   status
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_CAM,
      S_WAIT_CAM,
      S_MUL_X,
      S_MUL_Y,
      S_RAY_Y,
      S_DIV_DX,
      S_WAIT_DX,
      S_DIV_DY,
      S_WAIT_DY,
      S_SIDE_X,
      S_SIDE_Y,
      S_STEP,
      S_LOOK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;
   gdrc_pkg::dp_op_type op;

   always_comb begin
      accept       = req_valid && ready_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = gdrc_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            op = gdrc_pkg::OP_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (accept && (req_kind == gdrc_pkg::KIND_CAST)) begin
               state_in = S_DIV_CAM;
               ready_in = 1'b0;
            end
         end
         S_DIV_CAM: begin
            op       = gdrc_pkg::OP_DIV_CAM;
            state_in = S_WAIT_CAM;
         end
         S_WAIT_CAM: begin
            if (status.div_done) begin
               op       = gdrc_pkg::OP_CAM;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            op       = gdrc_pkg::OP_MUL_X;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            op       = gdrc_pkg::OP_MUL_Y;
            state_in = S_RAY_Y;
         end
         S_RAY_Y: begin
            op       = gdrc_pkg::OP_RAY_Y;
            state_in = S_DIV_DX;
         end
         S_DIV_DX: begin
            op       = gdrc_pkg::OP_DIV_DX;
            state_in = S_WAIT_DX;
         end
         S_WAIT_DX: begin
            if (status.div_done) begin
               op       = gdrc_pkg::OP_DX;
               state_in = S_DIV_DY;
            end
         end
         S_DIV_DY: begin
            op       = gdrc_pkg::OP_DIV_DY;
            state_in = S_WAIT_DY;
         end
         S_WAIT_DY: begin
            if (status.div_done) begin
               op       = gdrc_pkg::OP_DY;
               state_in = S_SIDE_X;
            end
         end
         S_SIDE_X: begin
            op       = gdrc_pkg::OP_SIDE_X;
            state_in = S_SIDE_Y;
         end
         S_SIDE_Y: begin
            op       = gdrc_pkg::OP_SIDE_Y;
            state_in = S_STEP;
         end
         S_STEP: begin
            op       = gdrc_pkg::OP_STEP;
            state_in = status.step_out ? S_DONE : S_LOOK;
         end
         S_LOOK: begin
            op       = gdrc_pkg::OP_LOOK;
            state_in = (status.cell_hit || status.count_last) ? S_DONE : S_STEP;
         end
         S_DONE: begin
            if (out_free) begin
               op           = gdrc_pkg::OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               ready_in     = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.op     = op;
   assign cmd.accept = accept;
   assign req_ready  = ready_ff;
   assign rsp_valid  = rsp_valid_ff;

endmodule

// ===== hdl/gdrc_checker.sv =====
// port-level checks of the ray caster core, bound to the top level
// depends on grid_dda_ray_caster_core_defines.svh
`include "grid_dda_ray_caster_core_defines.svh"

module gdrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_ray_column,
   input logic [17:0] rsp_wall_distance,
   input logic        rsp_hit_side,
   input logic [7:0]  rsp_wall_value,
   input logic        rsp_out_of_bounds
);

   logic [38:0] rsp_payload;

   assign rsp_payload = {rsp_ray_column, rsp_wall_distance, rsp_hit_side, rsp_wall_value,
                         rsp_out_of_bounds};

   // a stalled result stays offered
   `GDRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result keeps its payload
   `GDRC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // no transaction is taken right after reset, where the clearing sweep starts
   `GDRC_ASSERT_NOW(a_clear_after_reset, clock, 1'b0, $past(reset), !req_ready)

   // a hit carries a nonzero cell, a miss carries zero
   `GDRC_ASSERT_NOW(a_hit_value, clock, reset, rsp_valid, rsp_out_of_bounds == (rsp_wall_value == 8'd0))

endmodule

bind grid_dda_ray_caster_core gdrc_checker u_gdrc_checker (.*);
